FILE: hdl/lfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the LRU frame replacer
// Request codes, field widths and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package lfr_pkg;

	// Fixed field widths
	localparam int FRAME_W     = 6;
	localparam int CNT_W       = 7;
	localparam int ACT_W       = 2;
	localparam int FRAME_SPACE = 64;

	// Request kinds
	typedef enum logic [ACT_W-1:0] {
		ACT_VICTIM = 2'd0,
		ACT_PIN    = 2'd1,
		ACT_UNPIN  = 2'd2,
		ACT_SIZE   = 2'd3
	} action_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // request transfer this cycle
		logic scan;     // list scan / compaction step
		logic finish;   // last scan cycle, post the result
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic res_pend;   // a result waits for the output register
		logic need_scan;  // current request must walk the list
		logic scan_done;  // every entry read and handled
	} stat_t;

endpackage

FILE: hdl/lfr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_req_if: request channel
// Valid/ready channel carrying one replacer request.
// ----------------------------------------------------------------------------
interface lfr_req_if;

	logic                        valid;
	logic                        ready;
	logic [lfr_pkg::ACT_W-1:0]   action;
	logic [lfr_pkg::FRAME_W-1:0] frame_num;

	modport source (output valid, output action, output frame_num, input ready);
	modport sink   (input valid, input action, input frame_num, output ready);

endinterface

FILE: hdl/lfr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_rsp_if: result channel
// Valid/ready channel carrying one replacer result.
// ----------------------------------------------------------------------------
interface lfr_rsp_if;

	logic                        valid;
	logic                        ready;
	logic                        victim_valid;
	logic [lfr_pkg::FRAME_W-1:0] victim_frame;
	logic [lfr_pkg::CNT_W-1:0]   evictable_count;

	modport source (output valid, output victim_valid, output victim_frame,
		output evictable_count, input ready);
	modport sink   (input valid, input victim_valid, input victim_frame,
		input evictable_count, output ready);

endinterface

FILE: hdl/lfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ctrl: replacer controller
// Takes requests when the datapath can hold a result and sequences list scans.
// ----------------------------------------------------------------------------
module lfr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lfr_pkg::stat_t st,
	output lfr_pkg::cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;

	// Command decode
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = !st.res_pend;
				cmd.accept = req_valid && !st.res_pend;
			end
			ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.finish = st.scan_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && st.need_scan) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (st.scan_done) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/lfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_datapath: replacer list storage and result path
// Order memory, listed flags, entry count, scan pointer and output register.
// ----------------------------------------------------------------------------
module lfr_datapath #(
	parameter int NUM_FRAMES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lfr_pkg::ACT_W-1:0]   action,
	input  logic [lfr_pkg::FRAME_W-1:0] frame_num,
	input  lfr_pkg::cmd_t               cmd,
	output lfr_pkg::stat_t              st,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        out_victim_valid,
	output logic [lfr_pkg::FRAME_W-1:0] out_victim_frame,
	output logic [lfr_pkg::CNT_W-1:0]   out_count
);

	// List can never hold more distinct frames than the frame space
	localparam int DEPTH = (NUM_FRAMES < lfr_pkg::FRAME_SPACE) ? NUM_FRAMES
		: lfr_pkg::FRAME_SPACE;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = lfr_pkg::CNT_W;
	localparam int FW = lfr_pkg::FRAME_W;

	// Order memory, oldest entry at address 0
	logic [FW-1:0] mem [DEPTH];
	logic [FW-1:0] rd_data_q;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_wa;
	logic [FW-1:0] mem_wd;

	logic [lfr_pkg::FRAME_SPACE-1:0] listed_q;
	logic [CW-1:0]                   count_q;

	// Request context and scan state
	logic          op_victim_q;
	logic [FW-1:0] frame_q;
	logic [CW-1:0] rd_ptr_q;
	logic          rv_q;
	logic [AW-1:0] rv_addr_q;
	logic          found_q;
	logic [FW-1:0] vic_frame_q;

	// Pending result and output register
	logic          res_pend_q;
	logic          res_vv_q;
	logic [FW-1:0] res_vf_q;
	logic [CW-1:0] res_cnt_q;
	logic          out_vld_q;
	logic          out_vv_q;
	logic [FW-1:0] out_vf_q;
	logic [CW-1:0] out_cnt_q;

	logic in_range;
	logic is_victim;
	logic pin_hit;
	logic unpin_ok;
	logic issue;
	logic match;
	logic out_take;

	// Request decode
	assign in_range  = (32'(frame_num) < NUM_FRAMES);
	assign is_victim = (action == lfr_pkg::ACT_VICTIM);
	assign pin_hit   = (action == lfr_pkg::ACT_PIN) && in_range && listed_q[frame_num];
	assign unpin_ok  = (action == lfr_pkg::ACT_UNPIN) && in_range && !listed_q[frame_num]
		&& (count_q < CW'(DEPTH));

	// Scan control
	assign issue = (rd_ptr_q < count_q);
	assign match = op_victim_q || (rd_data_q == frame_q);

	assign st.need_scan = (is_victim && (count_q != '0)) || pin_hit;
	assign st.scan_done = !issue && !rv_q;
	assign st.res_pend  = res_pend_q;

	// Memory port control: append on unpin, move down after the hit on scan
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = cmd.scan && issue;
		if (cmd.accept && unpin_ok) begin
			mem_we = 1'b1;
			mem_wa = count_q[AW-1:0];
			mem_wd = frame_num;
		end else if (cmd.scan && rv_q && found_q) begin
			mem_we = 1'b1;
			mem_wa = rv_addr_q - AW'(1);
			mem_wd = rd_data_q;
		end
	end

	// Order memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_data_q <= mem[rd_ptr_q[AW-1:0]];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_victim_q <= is_victim;
			frame_q     <= frame_num;
		end
		if (cmd.scan) rv_addr_q <= rd_ptr_q[AW-1:0];
		if (cmd.scan && rv_q && !found_q && op_victim_q) vic_frame_q <= rd_data_q;
	end

	// List state and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			rv_q     <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				rd_ptr_q <= '0;
				rv_q     <= 1'b0;
				found_q  <= 1'b0;
				if (pin_hit) listed_q[frame_num] <= 1'b0;
				if (unpin_ok) begin
					listed_q[frame_num] <= 1'b1;
					count_q             <= count_q + CW'(1);
				end
			end
			if (cmd.scan) begin
				rv_q <= issue;
				if (issue) rd_ptr_q <= rd_ptr_q + CW'(1);
				if (rv_q && !found_q && match) begin
					found_q <= 1'b1;
					if (op_victim_q) listed_q[rd_data_q] <= 1'b0;
				end
			end
			if (cmd.finish) count_q <= count_q - CW'(1);
		end
	end

	// Result staging
	assign out_take = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept && !st.need_scan) begin
			res_vv_q  <= 1'b0;
			res_vf_q  <= '0;
			res_cnt_q <= unpin_ok ? count_q + CW'(1) : count_q;
		end else if (cmd.finish) begin
			res_vv_q  <= op_victim_q;
			res_vf_q  <= op_victim_q ? vic_frame_q : '0;
			res_cnt_q <= count_q - CW'(1);
		end
		if (res_pend_q && out_take) begin
			out_vv_q  <= res_vv_q;
			out_vf_q  <= res_vf_q;
			out_cnt_q <= res_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if ((cmd.accept && !st.need_scan) || cmd.finish) begin
				res_pend_q <= 1'b1;
			end else if (res_pend_q && out_take) begin
				res_pend_q <= 1'b0;
			end
			if (res_pend_q && out_take) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_vld_q;
	assign out_victim_valid = out_vv_q;
	assign out_victim_frame = out_vf_q;
	assign out_count        = out_cnt_q;

endmodule

FILE: hdl/lru_frame_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer: least-recently-unpinned frame replacer
// Tracks evictable buffer pool frames in unpin order and picks victims.
// ----------------------------------------------------------------------------
// Usage:
//  req carries action (victim, pin, unpin, size query) and frame_num; rsp
//  returns victim_valid, victim_frame and the evictable count after the
//  request. Exactly one result per request, in request order.
//  Requests with no scan (unpin, size query, pin of an unlisted frame and
//  victim on an empty list) pass their result through the pending result
//  register to the output register. Victim and pin of a listed frame walk
//  the order memory one entry per cycle through its single registered read
//  port. One request is worked on at a time; a new request is taken while
//  an earlier result still sits in the output register, but intake stalls
//  during a scan and while a finished result waits for the output register.
//  Reset clears the listed flags and the count at once; the order memory
//  needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module lru_frame_replacer #(
	parameter int NUM_FRAMES = 64
) (
	input logic        clk,
	input logic        arst_n,
	lfr_req_if.sink    req,
	lfr_rsp_if.source  rsp
);

	lfr_pkg::cmd_t  cmd;
	lfr_pkg::stat_t st;
	logic           ready;

	lfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.st        (st),
		.cmd       (cmd)
	);

	lfr_datapath #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.action           (req.action),
		.frame_num        (req.frame_num),
		.cmd              (cmd),
		.st               (st),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_victim_valid (rsp.victim_valid),
		.out_victim_frame (rsp.victim_frame),
		.out_count        (rsp.evictable_count)
	);

	assign req.ready = ready;

endmodule

FILE: hdl/lfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_checker: port-level checks of the LRU frame replacer
// Result encoding and result channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
module lfr_checker #(
	parameter int NUM_FRAMES = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        victim_valid,
	input logic [lfr_pkg::FRAME_W-1:0] victim_frame,
	input logic [lfr_pkg::CNT_W-1:0]   evictable_count
);

	localparam int CAP = (NUM_FRAMES < lfr_pkg::FRAME_SPACE) ? NUM_FRAMES
		: lfr_pkg::FRAME_SPACE;

	// No victim means a zero frame number
	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !victim_valid) |-> (victim_frame == '0))
		else $error("victim_frame nonzero without a victim");

	// Count never exceeds the list capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(evictable_count) <= CAP))
		else $error("evictable_count above capacity");

	// A stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		($stable(victim_valid) && $stable(victim_frame) && $stable(evictable_count)))
		else $error("result payload changed while stalled");

endmodule

bind lru_frame_replacer lfr_checker #(
	.NUM_FRAMES (NUM_FRAMES)
) u_lfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.victim_valid    (rsp.victim_valid),
	.victim_frame    (rsp.victim_frame),
	.evictable_count (rsp.evictable_count)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU frame replacer
// Requests go in through the request channel and every result is compared
// with a behavioral list model kept alongside. Directed requests cover the
// corner cases: empty list, repeated unpin, pin of head, tail and unlisted
// frames. Random phases alternate between filling the list and draining it,
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FRAME_W      = lfr_pkg::FRAME_W;
	localparam int CNT_W        = lfr_pkg::CNT_W;
	localparam int FRAME_SPACE  = lfr_pkg::FRAME_SPACE;
	localparam int FRAMES       = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 80;
	localparam int SHOWN_ERRORS = 10;

	typedef struct {
		logic                victim_valid;
		logic [FRAME_W-1:0]  victim_frame;
		logic [CNT_W-1:0]    evictable_count;
	} replacer_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lfr_req_if req_ch ();
	lfr_rsp_if rsp_ch ();

	lru_frame_replacer #(.NUM_FRAMES(FRAMES)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model state: evictable frames oldest first, plus a listed flag per frame
	logic [FRAME_W-1:0] evict_order[$];
	logic [FRAME_SPACE-1:0] frame_listed;

	replacer_result_t pending_results[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;

	always #5 clk = ~clk;

	// Apply one request to the list model and return the result it produces
	function automatic replacer_result_t apply_request(lfr_pkg::action_t act,
		logic [FRAME_W-1:0] frame);
		replacer_result_t res;
		bit in_range;
		in_range = int'(frame) < FRAMES;
		res.victim_valid = 1'b0;
		res.victim_frame = '0;
		case (act)
			lfr_pkg::ACT_VICTIM: begin
				if (evict_order.size() > 0) begin
					res.victim_valid = 1'b1;
					res.victim_frame = evict_order.pop_front();
					frame_listed[res.victim_frame] = 1'b0;
				end
			end
			lfr_pkg::ACT_PIN: begin
				if (in_range && frame_listed[frame]) begin
					foreach (evict_order[i]) begin
						if (evict_order[i] == frame) begin
							evict_order.delete(i);
							break;
						end
					end
					frame_listed[frame] = 1'b0;
				end
			end
			lfr_pkg::ACT_UNPIN: begin
				if (in_range && !frame_listed[frame] && evict_order.size() < FRAMES) begin
					evict_order.push_back(frame);
					frame_listed[frame] = 1'b1;
				end
			end
			default: ;
		endcase
		res.evictable_count = CNT_W'(evict_order.size());
		return res;
	endfunction

	// Drive one request; valid stays high across back-to-back transfers
	task automatic send_request(lfr_pkg::action_t act, logic [FRAME_W-1:0] frame);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.frame_num <= frame;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_results.push_back(apply_request(act, frame));
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result check and receiver stall pattern
	always @(posedge clk) begin
		replacer_result_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS)
					$display("%0t: unexpected result transfer vv=%0b vf=%0d cnt=%0d", $realtime,
						rsp_ch.victim_valid, rsp_ch.victim_frame, rsp_ch.evictable_count);
			end else begin
				exp_res = pending_results.pop_front();
				if (rsp_ch.victim_valid !== exp_res.victim_valid ||
					rsp_ch.victim_frame !== exp_res.victim_frame ||
					rsp_ch.evictable_count !== exp_res.evictable_count) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN_ERRORS)
						$display("%0t: expected vv=%0b vf=%0d cnt=%0d, got vv=%0b vf=%0d cnt=%0d",
							$realtime, exp_res.victim_valid, exp_res.victim_frame,
							exp_res.evictable_count, rsp_ch.victim_valid,
							rsp_ch.victim_frame, rsp_ch.evictable_count);
				end
			end
		end
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
	end

	// Run time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Corner cases on a short list
	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_request(lfr_pkg::ACT_SIZE, 6'd0);
		send_request(lfr_pkg::ACT_VICTIM, 6'd63);    // empty list
		send_request(lfr_pkg::ACT_PIN, 6'd5);        // pin of unlisted frame
		send_request(lfr_pkg::ACT_UNPIN, 6'd0);
		send_request(lfr_pkg::ACT_UNPIN, 6'd63);
		send_request(lfr_pkg::ACT_UNPIN, 6'd0);      // already listed, keeps its place
		send_request(lfr_pkg::ACT_SIZE, 6'd63);
		send_request(lfr_pkg::ACT_UNPIN, 6'd21);
		send_request(lfr_pkg::ACT_UNPIN, 6'd42);
		send_request(lfr_pkg::ACT_PIN, 6'd63);       // middle of list
		send_request(lfr_pkg::ACT_PIN, 6'd5);
		send_request(lfr_pkg::ACT_VICTIM, 6'd0);
		send_request(lfr_pkg::ACT_PIN, 6'd42);       // tail of list
		send_request(lfr_pkg::ACT_PIN, 6'd21);       // head, list becomes empty
		send_request(lfr_pkg::ACT_VICTIM, 6'd21);
		send_request(lfr_pkg::ACT_UNPIN, 6'd1);
		send_request(lfr_pkg::ACT_UNPIN, 6'd2);
		send_request(lfr_pkg::ACT_UNPIN, 6'd62);
		send_request(lfr_pkg::ACT_VICTIM, 6'd42);
		send_request(lfr_pkg::ACT_VICTIM, 6'd0);
		send_request(lfr_pkg::ACT_VICTIM, 6'd0);
		send_request(lfr_pkg::ACT_VICTIM, 6'd0);     // empty again
		send_request(lfr_pkg::ACT_SIZE, 6'd42);
		wait_for_results();
	endtask

	// Random traffic, alternating between filling and draining the list
	task automatic test_random(int unsigned num_items, int unsigned src_pct,
		int unsigned sink_pct);
		lfr_pkg::action_t act;
		logic [FRAME_W-1:0] frame;
		bit filling;
		int unsigned roll;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		filling = 1'b1;
		for (int n = 0; n < num_items; n++) begin
			if (n % 60 == 59)
				filling = !filling;
			roll  = $urandom_range(99);
			frame = FRAME_W'($urandom);
			if (filling)
				act = roll < 60 ? lfr_pkg::ACT_UNPIN : roll < 75 ? lfr_pkg::ACT_PIN :
					roll < 90 ? lfr_pkg::ACT_VICTIM : lfr_pkg::ACT_SIZE;
			else
				act = roll < 40 ? lfr_pkg::ACT_VICTIM : roll < 70 ? lfr_pkg::ACT_PIN :
					roll < 90 ? lfr_pkg::ACT_UNPIN : lfr_pkg::ACT_SIZE;
			// Steer unpin toward unlisted frames so the list grows
			if (act == lfr_pkg::ACT_UNPIN && $urandom_range(99) < 85) begin
				for (int t = 0; t < 8 && frame_listed[frame]; t++)
					frame = FRAME_W'($urandom);
			end
			// Mostly pin frames that are listed, anywhere in the list
			if (act == lfr_pkg::ACT_PIN && evict_order.size() > 0 && $urandom_range(99) < 70)
				frame = evict_order[$urandom_range(evict_order.size() - 1)];
			send_request(act, frame);
		end
		wait_for_results();
	endtask

	initial begin
		frame_listed = '0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.action    <= lfr_pkg::ACT_SIZE;
		req_ch.frame_num <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 0, 0);
		test_random(250, 78, 0);
		test_random(250, 0, 78);
		test_random(250, 13, 13);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
hdl/lfr_pkg.sv
hdl/lfr_req_if.sv
hdl/lfr_rsp_if.sv
hdl/lfr_ctrl.sv
hdl/lfr_datapath.sv
hdl/lru_frame_replacer.sv
hdl/lfr_checker.sv
verif/testbench.sv
